### rtl/nst_pkg.sv
// Shared constants and state types of the neighbor soft threshold block.
// Used by the front, back, top level and checker; depends on nothing.
package nst_pkg;

    localparam int COEF_WIDTH_DEF = 24;
    localparam int THR_W          = 24;
    localparam int FIFO_DEPTH_DEF = 4;

    // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT for every x below 2**32.
    localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ1,
        F_SQ2,
        F_SQRT,
        F_SHIFT,
        F_EMIT
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

### rtl/nst_fifo.sv
// Small register queue that carries shrink jobs from the front to the back.
// Uses nst_pkg for nothing but is kept in the same project style.
module nst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/nst_front.sv
// Front part: takes coefficients, forms the magnitude with an iterative square
// root, keeps the window and pushes one shrink job per answered coefficient.
// Depends on nst_pkg.
module nst_front #(
    parameter int COEF_WIDTH = nst_pkg::COEF_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [2*COEF_WIDTH-1:0]      s_tdata,
    input  logic                         s_tlast,
    input  logic                         cfg_valid,
    input  logic [nst_pkg::THR_W-1:0]    cfg_data,
    output logic                         job_valid,
    input  logic                         job_ready,
    output logic [2*COEF_WIDTH+nst_pkg::THR_W+1:0] job_data
);
    import nst_pkg::*;

    localparam int W     = COEF_WIDTH;
    localparam int MAG_W = W + 1;
    localparam int SUM_W = MAG_W + 3;
    localparam int CMP_W = (SUM_W + 1 > THR_W + 3) ? SUM_W + 1 : THR_W + 3;
    localparam int CNT_W = $clog2(W + 1);
    localparam int LOW_P = THR_W + 3 + 32;

    front_state_t state_reg, state_next;

    logic [THR_W-1:0]   base_reg, low_reg;
    logic [THR_W+2:0]   m7_reg;
    logic [LOW_P-1:0]   low_prod;
    logic [W-1:0]       ar_reg, ai_reg, re_reg;
    logic               end_reg;
    logic [2*W-1:0]     sq_reg, rad_reg;
    logic [W+1:0]       rem_reg, rem_try, trial;
    logic [W-1:0]       root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MAG_W-1:0]   mag_reg [5];
    logic [4:0]         vld_reg;
    logic [W-1:0]       real_reg [3];
    logic [1:0]         fill_reg, j_reg;
    logic [W-1:0]       re_in, im_in, re_abs, im_abs;
    logic [SUM_W-1:0]   sum;
    logic [2:0]         ncount;
    logic [CMP_W-1:0]   lhs, rhs;
    logic [THR_W-1:0]   thr;
    logic               emit_cond, push;

    assign re_in  = s_tdata[W-1:0];
    assign im_in  = s_tdata[2*W-1:W];
    assign re_abs = re_in[W-1] ? (~re_in) + 1'b1 : re_in;
    assign im_abs = im_in[W-1] ? (~im_in) + 1'b1 : im_in;

    assign low_prod = LOW_P'(m7_reg) * LOW_P'(DIV10_MUL);
    assign rem_try  = {rem_reg[W-1:0], rad_reg[2*W-1:2*W-2]};
    assign trial    = {root_reg, 2'b01};

    always_comb
    begin
        sum    = '0;
        ncount = '0;
        for (int p = 0; p < 5; p++)
        begin
            if (vld_reg[p] && (p != int'(j_reg)) && (p <= int'(j_reg) + 2))
            begin
                sum    = sum + SUM_W'(mag_reg[p]);
                ncount = ncount + 3'd1;
            end
        end
        lhs = CMP_W'({sum, 1'b0});
        rhs = CMP_W'(ncount) * CMP_W'(base_reg);
        thr = (lhs > rhs) ? low_reg : base_reg;
    end

    assign emit_cond = end_reg || (j_reg == 2'd2);
    assign job_valid = (state_reg == F_EMIT) && emit_cond;
    assign push      = job_valid && job_ready;
    assign job_data  = {(j_reg == 2'd0), real_reg[j_reg], thr, mag_reg[{1'b0, j_reg}]};
    assign s_tready  = (state_reg == F_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (s_tvalid) state_next = F_SQ1;
            F_SQ1:   state_next = F_SQ2;
            F_SQ2:   state_next = F_SQRT;
            F_SQRT:  if (cnt_reg == CNT_W'(W - 1)) state_next = F_SHIFT;
            F_SHIFT: state_next = F_EMIT;
            F_EMIT:
            begin
                if (!emit_cond)
                begin
                    state_next = F_IDLE;
                end
                else if (push && (j_reg == 2'd0 || !end_reg))
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            base_reg  <= '0;
            vld_reg   <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (state_reg == F_SQ2)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == F_SQRT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == F_SHIFT)
            begin
                vld_reg  <= {vld_reg[3:0], 1'b1};
                fill_reg <= fill_reg + 1'b1;
                j_reg    <= fill_reg;
            end
            if (state_reg == F_EMIT && push && !(j_reg == 2'd0 || !end_reg))
            begin
                j_reg <= j_reg - 1'b1;
            end
            if (state_reg == F_EMIT && state_next == F_IDLE)
            begin
                if (end_reg)
                begin
                    vld_reg  <= '0;
                    fill_reg <= '0;
                end
                else if (fill_reg == 2'd3)
                begin
                    fill_reg <= 2'd2;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m7_reg  <= {base_reg, 3'b000} - {3'b000, base_reg};
        low_reg <= low_prod[DIV10_SHIFT +: THR_W];
        if (state_reg == F_IDLE && s_tvalid)
        begin
            ar_reg  <= re_abs;
            ai_reg  <= im_abs;
            re_reg  <= re_in;
            end_reg <= s_tlast;
        end
        if (state_reg == F_SQ1)
        begin
            sq_reg <= (2*W)'(ar_reg) * (2*W)'(ar_reg);
        end
        if (state_reg == F_SQ2)
        begin
            rad_reg  <= sq_reg + (2*W)'(ai_reg) * (2*W)'(ai_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == F_SQRT)
        begin
            rad_reg <= {rad_reg[2*W-3:0], 2'b00};
            if (rem_try >= trial)
            begin
                rem_reg  <= rem_try - trial;
                root_reg <= {root_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_try;
                root_reg <= {root_reg[W-2:0], 1'b0};
            end
        end
        if (state_reg == F_SHIFT)
        begin
            for (int i = 4; i > 0; i--)
            begin
                mag_reg[i] <= mag_reg[i-1];
            end
            mag_reg[0] <= MAG_W'(root_reg);
            real_reg[2] <= real_reg[1];
            real_reg[1] <= real_reg[0];
            real_reg[0] <= re_reg;
        end
    end

endmodule

### rtl/nst_back.sv
// Back part: multiplies the absolute real part by the threshold margin, divides
// by the magnitude one quotient bit a cycle and holds the result for the sink.
// Depends on nst_pkg.
module nst_back #(
    parameter int COEF_WIDTH = nst_pkg::COEF_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   job_valid,
    output logic                                   job_ready,
    input  logic [2*COEF_WIDTH+nst_pkg::THR_W+1:0] job_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((COEF_WIDTH+7)/8)*8-1:0]        m_tdata,
    output logic                                   m_tlast
);
    import nst_pkg::*;

    localparam int W     = COEF_WIDTH;
    localparam int MAG_W = W + 1;
    localparam int P_W   = W + MAG_W;
    localparam int CW    = (MAG_W > THR_W) ? MAG_W : THR_W;
    localparam int CNT_W = $clog2(W + 1);
    localparam int OUT_W = ((W + 7) / 8) * 8;

    back_state_t state_reg, state_next;

    logic [MAG_W-1:0] mag_reg, rem_reg;
    logic [THR_W-1:0] thr_reg;
    logic [W-1:0]     are_reg, q_reg;
    logic             neg_reg, last_reg, zero_reg;
    logic [P_W-1:0]   prod_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     job_re, job_are;
    logic [CW-1:0]    mag_x, thr_x, diff_x;
    logic [MAG_W:0]   rem_try;
    logic [W-1:0]     q_fin;

    assign job_re  = job_data[MAG_W+THR_W +: W];
    assign job_are = job_re[W-1] ? (~job_re) + 1'b1 : job_re;
    assign mag_x   = CW'(mag_reg);
    assign thr_x   = CW'(thr_reg);
    assign diff_x  = mag_x - thr_x;
    assign rem_try = {rem_reg, prod_reg[W-1]};
    assign q_fin   = neg_reg ? (~q_reg) + 1'b1 : q_reg;

    assign job_ready = (state_reg == B_IDLE);
    assign m_tvalid  = (state_reg == B_OUT);
    assign m_tdata   = OUT_W'(zero_reg ? '0 : q_fin);
    assign m_tlast   = last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (job_valid) state_next = B_MUL;
            B_MUL:  state_next = B_DIV;
            B_DIV:  if (cnt_reg == CNT_W'(W)) state_next = B_OUT;
            B_OUT:  if (m_tready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_MUL)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == B_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && job_valid)
        begin
            mag_reg  <= job_data[MAG_W-1:0];
            thr_reg  <= job_data[MAG_W +: THR_W];
            are_reg  <= job_are;
            neg_reg  <= job_re[W-1];
            last_reg <= job_data[2*W+THR_W+1];
        end
        if (state_reg == B_MUL)
        begin
            zero_reg <= (mag_reg == '0) || (mag_x <= thr_x);
            prod_reg <= P_W'(are_reg) * P_W'(diff_x[MAG_W-1:0]);
        end
        if (state_reg == B_DIV)
        begin
            if (cnt_reg == '0)
            begin
                rem_reg  <= prod_reg[P_W-1:W];
                q_reg    <= '0;
            end
            else
            begin
                prod_reg <= {prod_reg[P_W-2:0], 1'b0};
                if (rem_try >= {1'b0, mag_reg})
                begin
                    rem_reg <= MAG_W'(rem_try - {1'b0, mag_reg});
                    q_reg   <= {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_try[MAG_W-1:0];
                    q_reg   <= {q_reg[W-2:0], 1'b0};
                end
            end
        end
    end

endmodule

### rtl/neighbor_soft_threshold.sv
// Throughput is set by the bit-serial square root in the front, which takes no new
// coefficient while one is in work, and by the serial divider in the back, which
// takes no new job until its result is taken; one result per coefficient, up to
// three of them after the last coefficient of a level.
// Reset clears the window, the job queue and base_threshold; no clearing pass.
module neighbor_soft_threshold #(
    parameter int COEF_WIDTH = nst_pkg::COEF_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*COEF_WIDTH-1:0]           s_tdata,  // coef_real, coef_imag
    input  logic                              s_tlast,  // level_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((COEF_WIDTH+7)/8)*8-1:0]   m_tdata,  // shrunk_real, zero fill
    output logic                              m_tlast,  // last_of_level
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nst_pkg::THR_W-1:0]         cfg_data  // base_threshold
);
    import nst_pkg::*;

    localparam int JOB_W = 2 * COEF_WIDTH + THR_W + 2;

    logic             fj_valid, fj_ready, bj_valid, bj_ready;
    logic [JOB_W-1:0] fj_data, bj_data;

    assign cfg_ready = 1'b1;

    nst_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_data  (fj_data)
    );

    nst_fifo #(.WIDTH(JOB_W), .DEPTH(FIFO_DEPTH_DEF)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fj_valid),
        .in_ready  (fj_ready),
        .in_data   (fj_data),
        .out_valid (bj_valid),
        .out_ready (bj_ready),
        .out_data  (bj_data)
    );

    nst_back #(.COEF_WIDTH(COEF_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job_data  (bj_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### rtl/nst_checker.sv
// Port-level checks of neighbor_soft_threshold, attached by the bind below.
// Depends on nst_pkg and the top level's ports.
module nst_checker #(
    parameter int COEF_WIDTH = nst_pkg::COEF_WIDTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [((COEF_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic                            m_tlast
);
    import nst_pkg::*;

    a_no_out_in_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result shown during reset");

    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while the previous item is in work");

    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result follows without divider time");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind neighbor_soft_threshold nst_checker #(.COEF_WIDTH(COEF_WIDTH)) u_nst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/neighbor_soft_threshold_tb.sv
// Testbench for neighbor_soft_threshold: streams complex wavelet coefficients, predicts the
// shrunk real parts with a local model of the neighbor window, and checks every result item.
// Depends on nst_pkg and the neighbor_soft_threshold RTL.
class shrink_scoreboard;
    logic [23:0] thr_base;
    logic [24:0] mags [5];
    bit          mvalid [5];
    logic [23:0] reals [3];
    int          pending;
    logic [24:0] exp_q [$];
    int          errors;

    function new();
        thr_base = '0;
        errors   = 0;
        clear_window();
    endfunction

    function void clear_window();
        for (int i = 0; i < 5; i++)
        begin
            mags[i]   = '0;
            mvalid[i] = 0;
        end
        for (int i = 0; i < 3; i++)
            reals[i] = '0;
        pending = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function logic [63:0] abs24(logic [23:0] v);
        logic [23:0] n;
        n = (~v) + 24'd1;
        return v[23] ? {40'd0, n} : {40'd0, v};
    endfunction

    function logic [23:0] shrink_pos(int j);
        logic [63:0] sum;
        logic [63:0] cnt;
        logic [63:0] thr;
        logic [63:0] mag;
        logic [63:0] are;
        logic [63:0] q;
        int          p;
        sum = 0;
        cnt = 0;
        for (int d = -2; d <= 2; d++)
        begin
            p = j + d;
            if (d != 0 && p >= 0 && p <= 4 && mvalid[p])
            begin
                sum += mags[p];
                cnt++;
            end
        end
        thr = thr_base;
        if (cnt > 0 && 2 * sum > cnt * thr_base)
            thr = (64'(thr_base) * 7) / 10;
        mag = mags[j];
        if (mag == 0 || mag <= thr)
            return '0;
        are = abs24(reals[j]);
        q = (are * (mag - thr)) / mag;
        return reals[j][23] ? -q[23:0] : q[23:0];
    endfunction

    function void note_input(logic [23:0] re, logic [23:0] im, bit last);
        logic [63:0] ar;
        logic [63:0] ai;
        ar = abs24(re);
        ai = abs24(im);
        for (int i = 4; i > 0; i--)
        begin
            mags[i]   = mags[i-1];
            mvalid[i] = mvalid[i-1];
        end
        reals[2] = reals[1];
        reals[1] = reals[0];
        mags[0]   = 25'(int_sqrt(ar * ar + ai * ai));
        mvalid[0] = 1;
        reals[0]  = re;
        pending++;
        if (pending >= 3)
        begin
            exp_q.push_back({1'b0, shrink_pos(2)});
            pending = 2;
        end
        if (last)
        begin
            for (int i = pending - 1; i >= 0; i--)
                exp_q.push_back({(i == 0) ? 1'b1 : 1'b0, shrink_pos(i)});
            clear_window();
        end
    endfunction

    function void check_result(logic [23:0] val, bit last);
        logic [24:0] e;
        if (exp_q.size() == 0)
        begin
            $error("unexpected result item shrunk_real=%h", val);
            errors++;
            return;
        end
        e = exp_q.pop_front();
        if (e[23:0] !== val)
        begin
            $error("shrunk_real expected %h actual %h", e[23:0], val);
            errors++;
        end
        if (e[24] !== last)
        begin
            $error("last_of_level expected %0b actual %0b", e[24], last);
            errors++;
        end
    endfunction
endclass

module neighbor_soft_threshold_tb;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] cfg_data;

    shrink_scoreboard sb;
    bit quiet;
    int idle_cycles;
    int coef_count;
    int result_count;

    neighbor_soft_threshold u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    task automatic send_coef(logic [23:0] re, logic [23:0] im, bit last);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {im, re};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_input(re, im, last);
        coef_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.exp_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_thr(logic [23:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.thr_base = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic [23:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(int'($urandom_range(0, 8192)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tlast);
            result_count++;
        end
    end

    initial
    begin
        m_tready = 0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            m_tready <= 1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int len;
        sb = new();
        quiet = 0;
        idle_cycles = 0;
        coef_count = 0;
        result_count = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Several thresholds, zero magnitude, extremes, single-item and longer levels.
        send_coef(24'h000000, 24'h000000, 1);
        send_coef(24'h800000, 24'h800000, 1);
        write_thr(24'h001000);
        send_coef(24'h7FFFFF, 24'h000000, 0);
        send_coef(24'h000000, 24'h000000, 1);
        send_coef(24'h000800, 24'h000000, 0);
        send_coef(24'hFFF000, 24'h001000, 0);
        send_coef(24'h800000, 24'h7FFFFF, 0);
        send_coef(24'h000100, 24'hFFFF00, 0);
        send_coef(24'h000000, 24'h000000, 0);
        send_coef(24'h001000, 24'h000000, 1);
        write_thr(24'hFFFFFF);
        send_coef(24'h7FFFFF, 24'h7FFFFF, 0);
        send_coef(24'h800000, 24'h800000, 0);
        send_coef(24'h123456, 24'hABCDEF, 1);
        write_thr(24'h000000);
        send_coef(24'h555555, 24'hAAAAAA, 0);
        send_coef(24'hAAAAAA, 24'h555555, 1);
        drain();

        for (int k = 0; k < 230; )
        begin
            if (k > 190)
                quiet = 1;
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: write_thr(24'h000000);
                    1: write_thr(24'hFFFFFF);
                    2: write_thr(24'($urandom_range(0, 24'h010000)));
                    default: write_thr(24'($urandom));
                endcase
            end
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
            for (int i = 0; i < len; i++)
            begin
                send_coef(rand_coef(), rand_coef(), i == len - 1);
                k++;
            end
        end
        drain();
        $display("Sent %0d coefficients and checked %0d results over several threshold settings.",
                 coef_count, result_count);
        if (sb.errors == 0 && sb.exp_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
